@@ hw/rtl/kts_pkg.sv @@
package kts_pkg;

    // track table size
    localparam int KEYS   = 64;
    localparam int KEY_AW = $clog2(KEYS);
    localparam int CNT_W  = $clog2(KEYS + 1);

    // shared divider geometry: quotient never exceeds one in q16
    localparam int DIV_DW = 49;
    localparam int DIV_SW = 33;
    localparam int DIV_QW = 17;

    localparam int SQRT_RW = 64;
    localparam int SQRT_QW = 32;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic REG_KEY_COUNT  = 1'b0;
    localparam logic REG_TRACK_KIND = 1'b1;

    localparam logic KIND_VECTOR = 1'b0;
    localparam logic KIND_QUAT   = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CLAMP     = 2'd1;
    localparam logic [1:0] ST_ZERO_SPAN = 2'd2;

    localparam logic [16:0] Q16_ONE = 17'h10000;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LD_A,
        CMD_LD_B,
        CMD_RAW,
        CMD_F_ZERO,
        CMD_F_ONE,
        CMD_DIV_F,
        CMD_F_DIV,
        CMD_MUL_BLEND,
        CMD_BLEND_RES,
        CMD_BLEND_A,
        CMD_ACC_CLR,
        CMD_MUL_SQ,
        CMD_ACC_SQ,
        CMD_SQRT,
        CMD_DIV_N,
        CMD_N_WR,
        CMD_MUL_DOT,
        CMD_ACC_DOT,
        CMD_NEG_B
    } kts_op_t;

    typedef enum logic [1:0] {
        DST_A,
        DST_B,
        DST_RES
    } kts_dst_t;

    typedef struct packed {
        kts_op_t           op;
        logic [1:0]        k;
        logic              src_b;
        kts_dst_t          dst;
        logic [KEY_AW-1:0] rd_addr;
        logic              key_wr;
        logic              smp_load;
    } kts_cmd_t;

    typedef struct packed {
        logic hit;
        logic den_zero;
        logic neg;
        logic over;
        logic div_done;
        logic sqrt_done;
        logic dot_neg;
    } kts_flags_t;

endpackage

@@ hw/rtl/kts_div.sv @@
module kts_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [kts_pkg::DIV_DW-1:0]  dividend,
    input  logic [kts_pkg::DIV_SW-1:0]  divisor,
    output logic                        done,
    output logic [kts_pkg::DIV_QW-1:0]  quotient
);

    localparam int CW = $clog2(kts_pkg::DIV_QW + 1);

    logic [kts_pkg::DIV_SW-1:0] rem_reg;
    logic [kts_pkg::DIV_SW-1:0] dsr_reg;
    logic [kts_pkg::DIV_QW-1:0] low_reg;
    logic [kts_pkg::DIV_QW-1:0] quot_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       done_reg;

    logic [kts_pkg::DIV_SW:0]   trial;
    logic [kts_pkg::DIV_SW:0]   diff;
    logic                       ge;

    // restoring step, one quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, low_reg[kts_pkg::DIV_QW-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = trial >= {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(kts_pkg::DIV_QW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, dividend[kts_pkg::DIV_DW-1:kts_pkg::DIV_QW]};
            low_reg  <= dividend[kts_pkg::DIV_QW-1:0];
            dsr_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= ge ? diff[kts_pkg::DIV_SW-1:0] : trial[kts_pkg::DIV_SW-1:0];
            low_reg  <= {low_reg[kts_pkg::DIV_QW-2:0], 1'b0};
            quot_reg <= {quot_reg[kts_pkg::DIV_QW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

@@ hw/rtl/kts_sqrt.sv @@
module kts_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [kts_pkg::SQRT_RW-1:0]  radicand,
    output logic                         done,
    output logic [kts_pkg::SQRT_QW-1:0]  root
);

    localparam int CW = $clog2(kts_pkg::SQRT_QW + 1);
    localparam int RW = kts_pkg::SQRT_QW + 2;

    logic [RW-1:0]                rem_reg;
    logic [kts_pkg::SQRT_QW-1:0]  root_reg;
    logic [kts_pkg::SQRT_RW-1:0]  rad_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         done_reg;

    logic [RW+1:0]                cur;
    logic [RW+1:0]                trial;
    logic [RW+1:0]                diff;
    logic                         ge;

    // digit-by-digit, two radicand bits per cycle
    always_comb
    begin
        cur   = {rem_reg, rad_reg[kts_pkg::SQRT_RW-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        diff  = cur - trial;
        ge    = cur >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(kts_pkg::SQRT_QW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            rad_reg  <= radicand;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= ge ? diff[RW-1:0] : cur[RW-1:0];
            root_reg <= {root_reg[kts_pkg::SQRT_QW-2:0], ge};
            rad_reg  <= {rad_reg[kts_pkg::SQRT_RW-3:0], 2'b00};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ hw/rtl/kts_datapath.sv @@
module kts_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  kts_pkg::kts_cmd_t   cmd,
    input  logic                track_kind,
    input  logic [5:0]          key_index,
    input  logic [31:0]         key_time,
    input  logic signed [31:0]  comp_x,
    input  logic signed [31:0]  comp_y,
    input  logic signed [31:0]  comp_z,
    input  logic signed [31:0]  comp_w,
    input  logic [31:0]         sample_time,
    output kts_pkg::kts_flags_t flags,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    output logic signed [31:0]  out_z,
    output logic signed [31:0]  out_w
);

    // key store
    logic [31:0]  mem_t [kts_pkg::KEYS];
    logic [127:0] mem_v [kts_pkg::KEYS];
    logic [31:0]  rd_time_reg;
    logic [127:0] rd_val_reg;

    logic [31:0]        t_reg;
    logic [31:0]        ta_reg;
    logic [31:0]        tb_reg;
    logic signed [31:0] va_reg  [4];
    logic signed [31:0] vb_reg  [4];
    logic signed [31:0] res_reg [4];
    logic [16:0]        f_reg;
    logic signed [65:0] prod_reg;
    logic [63:0]        acc_reg;

    logic [32:0] num;
    logic [32:0] den;
    logic [32:0] an;
    logic [32:0] ad;

    logic signed [31:0] va_k;
    logic signed [31:0] vb_k;
    logic signed [31:0] sel_v;
    logic [31:0]        mag;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [51:0]        blend_sum;
    logic [31:0]        blend_val;
    logic [64:0]        sq_sum;

    logic                         div_start;
    logic [kts_pkg::DIV_DW-1:0]   div_dvd;
    logic [kts_pkg::DIV_SW-1:0]   div_dsr;
    logic                         div_done;
    logic [kts_pkg::DIV_QW-1:0]   quot;
    logic                         sqrt_start;
    logic                         sqrt_done;
    logic [kts_pkg::SQRT_QW-1:0]  len;
    logic [31:0]                  nq;
    logic [31:0]                  nval;
    logic                         wr_ok;

    assign wr_ok = 32'(key_index) < kts_pkg::KEYS;

    always_ff @(posedge clk)
    begin
        if (cmd.key_wr && wr_ok)
        begin
            mem_t[kts_pkg::KEY_AW'(key_index)] <= key_time;
            mem_v[kts_pkg::KEY_AW'(key_index)] <= {comp_w, comp_z, comp_y, comp_x};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_time_reg <= mem_t[cmd.rd_addr];
        rd_val_reg  <= mem_v[cmd.rd_addr];
    end

    always_comb
    begin
        num = {1'b0, t_reg} - {1'b0, ta_reg};
        den = {1'b0, tb_reg} - {1'b0, ta_reg};
        an  = num[32] ? (~num + 33'd1) : num;
        ad  = den[32] ? (~den + 33'd1) : den;

        va_k  = va_reg[cmd.k];
        vb_k  = vb_reg[cmd.k];
        sel_v = cmd.src_b ? vb_k : va_k;
        mag   = sel_v[31] ? (~sel_v + 32'd1) : sel_v;

        case (cmd.op)
            kts_pkg::CMD_MUL_BLEND:
            begin
                mul_a = {vb_k[31], vb_k} - {va_k[31], va_k};
                mul_b = {16'b0, f_reg};
            end
            kts_pkg::CMD_MUL_SQ:
            begin
                mul_a = {sel_v[31], sel_v};
                mul_b = {sel_v[31], sel_v};
            end
            kts_pkg::CMD_MUL_DOT:
            begin
                mul_a = {va_k[31], va_k};
                mul_b = {vb_k[31], vb_k};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        // a + (b - a) * f, rounded half up in q16
        blend_sum = {{4{va_k[31]}}, va_k, 16'b0} + prod_reg[51:0] + 52'd32768;
        blend_val = blend_sum[47:16];

        sq_sum = {1'b0, acc_reg} + {1'b0, prod_reg[63:0]};

        div_start = (cmd.op == kts_pkg::CMD_DIV_F) || (cmd.op == kts_pkg::CMD_DIV_N);
        if (cmd.op == kts_pkg::CMD_DIV_F)
        begin
            div_dvd = {an, 16'b0};
            div_dsr = ad;
        end
        else
        begin
            div_dvd = {1'b0, mag, 16'b0} + {18'b0, len[31:1]};
            div_dsr = {1'b0, len};
        end

        sqrt_start = cmd.op == kts_pkg::CMD_SQRT;

        nq   = {15'b0, quot};
        nval = (len == '0) ? 32'd0 : (sel_v[31] ? (~nq + 32'd1) : nq);
    end

    kts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (quot)
    );

    kts_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_reg),
        .done     (sqrt_done),
        .root     (len)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (cmd.smp_load)
        begin
            t_reg      <= sample_time;
            res_reg[3] <= '0;
        end

        case (cmd.op)
            kts_pkg::CMD_LD_A:
            begin
                ta_reg    <= rd_time_reg;
                va_reg[0] <= rd_val_reg[31:0];
                va_reg[1] <= rd_val_reg[63:32];
                va_reg[2] <= rd_val_reg[95:64];
                va_reg[3] <= rd_val_reg[127:96];
            end
            kts_pkg::CMD_LD_B:
            begin
                tb_reg    <= rd_time_reg;
                vb_reg[0] <= rd_val_reg[31:0];
                vb_reg[1] <= rd_val_reg[63:32];
                vb_reg[2] <= rd_val_reg[95:64];
                vb_reg[3] <= rd_val_reg[127:96];
            end
            kts_pkg::CMD_RAW:
            begin
                res_reg[0] <= va_reg[0];
                res_reg[1] <= va_reg[1];
                res_reg[2] <= va_reg[2];
                res_reg[3] <= (track_kind == kts_pkg::KIND_QUAT) ? va_reg[3] : 32'sd0;
            end
            kts_pkg::CMD_F_ZERO:    f_reg <= '0;
            kts_pkg::CMD_F_ONE:     f_reg <= kts_pkg::Q16_ONE;
            kts_pkg::CMD_F_DIV:     f_reg <= quot;
            kts_pkg::CMD_BLEND_RES: res_reg[cmd.k] <= blend_val;
            kts_pkg::CMD_BLEND_A:   va_reg[cmd.k] <= blend_val;
            kts_pkg::CMD_ACC_CLR:   acc_reg <= '0;
            kts_pkg::CMD_ACC_SQ:    acc_reg <= sq_sum[64] ? '1 : sq_sum[63:0];
            kts_pkg::CMD_ACC_DOT:   acc_reg <= acc_reg + prod_reg[63:0];
            kts_pkg::CMD_NEG_B:
            begin
                vb_reg[0] <= -vb_reg[0];
                vb_reg[1] <= -vb_reg[1];
                vb_reg[2] <= -vb_reg[2];
                vb_reg[3] <= -vb_reg[3];
            end
            kts_pkg::CMD_N_WR:
            begin
                case (cmd.dst)
                    kts_pkg::DST_A:   va_reg[cmd.k]  <= nval;
                    kts_pkg::DST_B:   vb_reg[cmd.k]  <= nval;
                    kts_pkg::DST_RES: res_reg[cmd.k] <= nval;
                    default:          res_reg[cmd.k] <= nval;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        flags.hit       = t_reg < rd_time_reg;
        flags.den_zero  = tb_reg == ta_reg;
        flags.neg       = (num != '0) && (num[32] != den[32]);
        flags.over      = an > ad;
        flags.div_done  = div_done;
        flags.sqrt_done = sqrt_done;
        flags.dot_neg   = acc_reg[63];
    end

    assign out_x = res_reg[0];
    assign out_y = res_reg[1];
    assign out_z = res_reg[2];
    assign out_w = res_reg[3];

endmodule

@@ hw/rtl/kts_ctrl.sv @@
module kts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                opcode,
    input  logic [6:0]          key_count,
    input  logic                track_kind,
    input  kts_pkg::kts_flags_t flags,
    output logic                busy,
    output logic                done,
    output logic [1:0]          status,
    output kts_pkg::kts_cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_ONE_RD,
        S_ONE_LD,
        S_RAW,
        S_SRCH_RD,
        S_SRCH_CK,
        S_SEG_A,
        S_SEG_B,
        S_SEG_C,
        S_CHK,
        S_FDIV,
        S_MODE,
        S_VB_MUL,
        S_VB_WR,
        S_N_CLR,
        S_N_MUL,
        S_N_ADD,
        S_N_SQRT,
        S_N_SQW,
        S_N_DIV,
        S_N_DIVW,
        S_DOT_CLR,
        S_DOT_MUL,
        S_DOT_ADD,
        S_DOT_CHK,
        S_QB_MUL,
        S_QB_WR
    } state_t;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_MIX
    } phase_t;

    state_t                       state_reg, state_next;
    phase_t                       phase_reg, phase_next;
    logic [kts_pkg::KEY_AW-1:0]   idx_reg, idx_next;
    logic [kts_pkg::CNT_W-1:0]    n_reg, n_next;
    logic [1:0]                   k_reg, k_next;
    logic                         done_reg, done_next;
    logic [1:0]                   status_reg, status_next;
    logic [kts_pkg::CNT_W-1:0]    n_clamped;

    always_comb
    begin
        if (key_count == '0)
        begin
            n_clamped = kts_pkg::CNT_W'(1);
        end
        else if (32'(key_count) > kts_pkg::KEYS)
        begin
            n_clamped = kts_pkg::CNT_W'(kts_pkg::KEYS);
        end
        else
        begin
            n_clamped = kts_pkg::CNT_W'(key_count);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        done_next   = 1'b0;
        status_next = status_reg;

        cmd          = '0;
        cmd.op       = kts_pkg::CMD_NONE;
        cmd.k        = k_reg;
        cmd.src_b    = phase_reg == PH_B;
        cmd.rd_addr  = idx_reg;
        case (phase_reg)
            PH_A:    cmd.dst = kts_pkg::DST_A;
            PH_B:    cmd.dst = kts_pkg::DST_B;
            PH_MIX:  cmd.dst = kts_pkg::DST_RES;
            default: cmd.dst = kts_pkg::DST_RES;
        endcase

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == kts_pkg::OP_WRITE)
                    begin
                        cmd.key_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.smp_load = 1'b1;
                        status_next  = kts_pkg::ST_OK;
                        n_next       = n_clamped;
                        idx_next     = '0;
                        state_next   = (n_clamped == kts_pkg::CNT_W'(1)) ? S_ONE_RD : S_SRCH_RD;
                    end
                end
            end
            S_ONE_RD:
            begin
                state_next = S_ONE_LD;
            end
            S_ONE_LD:
            begin
                cmd.op     = kts_pkg::CMD_LD_A;
                state_next = S_RAW;
            end
            S_RAW:
            begin
                cmd.op     = kts_pkg::CMD_RAW;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SRCH_RD:
            begin
                cmd.rd_addr = idx_reg + kts_pkg::KEY_AW'(1);
                state_next  = S_SRCH_CK;
            end
            S_SRCH_CK:
            begin
                if (flags.hit)
                begin
                    state_next = S_SEG_A;
                end
                else if (32'(idx_reg) + 2 >= 32'(n_reg))
                begin
                    idx_next    = '0;
                    status_next = kts_pkg::ST_CLAMP;
                    state_next  = S_SEG_A;
                end
                else
                begin
                    idx_next   = idx_reg + kts_pkg::KEY_AW'(1);
                    state_next = S_SRCH_RD;
                end
            end
            S_SEG_A:
            begin
                state_next = S_SEG_B;
            end
            S_SEG_B:
            begin
                cmd.op      = kts_pkg::CMD_LD_A;
                cmd.rd_addr = idx_reg + kts_pkg::KEY_AW'(1);
                state_next  = S_SEG_C;
            end
            S_SEG_C:
            begin
                cmd.op     = kts_pkg::CMD_LD_B;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (flags.den_zero)
                begin
                    status_next = kts_pkg::ST_ZERO_SPAN;
                    state_next  = S_RAW;
                end
                else if (flags.neg)
                begin
                    cmd.op      = kts_pkg::CMD_F_ZERO;
                    status_next = kts_pkg::ST_CLAMP;
                    state_next  = S_MODE;
                end
                else if (flags.over)
                begin
                    cmd.op      = kts_pkg::CMD_F_ONE;
                    status_next = kts_pkg::ST_CLAMP;
                    state_next  = S_MODE;
                end
                else
                begin
                    cmd.op     = kts_pkg::CMD_DIV_F;
                    state_next = S_FDIV;
                end
            end
            S_FDIV:
            begin
                if (flags.div_done)
                begin
                    cmd.op     = kts_pkg::CMD_F_DIV;
                    state_next = S_MODE;
                end
            end
            S_MODE:
            begin
                k_next = '0;
                if (track_kind == kts_pkg::KIND_VECTOR)
                begin
                    state_next = S_VB_MUL;
                end
                else
                begin
                    phase_next = PH_A;
                    state_next = S_N_CLR;
                end
            end
            S_VB_MUL:
            begin
                cmd.op     = kts_pkg::CMD_MUL_BLEND;
                state_next = S_VB_WR;
            end
            S_VB_WR:
            begin
                cmd.op = kts_pkg::CMD_BLEND_RES;
                if (k_reg == 2'd2)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_VB_MUL;
                end
            end
            S_N_CLR:
            begin
                cmd.op     = kts_pkg::CMD_ACC_CLR;
                k_next     = '0;
                state_next = S_N_MUL;
            end
            S_N_MUL:
            begin
                cmd.op     = kts_pkg::CMD_MUL_SQ;
                state_next = S_N_ADD;
            end
            S_N_ADD:
            begin
                cmd.op = kts_pkg::CMD_ACC_SQ;
                if (k_reg == 2'd3)
                begin
                    state_next = S_N_SQRT;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_N_MUL;
                end
            end
            S_N_SQRT:
            begin
                cmd.op     = kts_pkg::CMD_SQRT;
                state_next = S_N_SQW;
            end
            S_N_SQW:
            begin
                if (flags.sqrt_done)
                begin
                    k_next     = '0;
                    state_next = S_N_DIV;
                end
            end
            S_N_DIV:
            begin
                cmd.op     = kts_pkg::CMD_DIV_N;
                state_next = S_N_DIVW;
            end
            S_N_DIVW:
            begin
                if (flags.div_done)
                begin
                    cmd.op = kts_pkg::CMD_N_WR;
                    if (k_reg == 2'd3)
                    begin
                        case (phase_reg)
                            PH_A:
                            begin
                                phase_next = PH_B;
                                state_next = S_N_CLR;
                            end
                            PH_B:
                            begin
                                state_next = S_DOT_CLR;
                            end
                            default:
                            begin
                                done_next  = 1'b1;
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_N_DIV;
                    end
                end
            end
            S_DOT_CLR:
            begin
                cmd.op     = kts_pkg::CMD_ACC_CLR;
                k_next     = '0;
                state_next = S_DOT_MUL;
            end
            S_DOT_MUL:
            begin
                cmd.op     = kts_pkg::CMD_MUL_DOT;
                state_next = S_DOT_ADD;
            end
            S_DOT_ADD:
            begin
                cmd.op = kts_pkg::CMD_ACC_DOT;
                if (k_reg == 2'd3)
                begin
                    state_next = S_DOT_CHK;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_DOT_MUL;
                end
            end
            S_DOT_CHK:
            begin
                if (flags.dot_neg)
                begin
                    cmd.op = kts_pkg::CMD_NEG_B;
                end
                k_next     = '0;
                state_next = S_QB_MUL;
            end
            S_QB_MUL:
            begin
                cmd.op     = kts_pkg::CMD_MUL_BLEND;
                state_next = S_QB_WR;
            end
            S_QB_WR:
            begin
                cmd.op = kts_pkg::CMD_BLEND_A;
                if (k_reg == 2'd3)
                begin
                    phase_next = PH_MIX;
                    state_next = S_N_CLR;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_QB_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_A;
            idx_reg    <= '0;
            n_reg      <= kts_pkg::CNT_W'(1);
            k_reg      <= '0;
            done_reg   <= 1'b0;
            status_reg <= kts_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            n_reg      <= n_next;
            k_reg      <= k_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign status = status_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_sample_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == kts_pkg::OP_SAMPLE) |=> busy)
        else $error("sample request did not start the sequencer");

    a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH_CK) |-> (32'(idx_reg) + 2 <= 32'(n_reg)))
        else $error("key search ran past the key count");

endmodule

@@ hw/rtl/keyframe_track_sampler.sv @@
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+---------------------------
// request   | opcode key_index key_time comp_x..w          | start high while busy low
//           | sample_time                                  |
// result    | out_x out_y out_z out_w status               | done strobe, one cycle
// config    | cfg_we cfg_index cfg_data                    | write at cfg_we, no wait
//
// a key write is stored in the cycle it is accepted and leaves busy low
// a sample is busy for the steps below and strobes done in the cycle after them;
// one key: read and copy it out; otherwise the key search reads keys in order (up to
// key_count-1, clamped to 1..64), then a zero span copies out the segment's first key,
// vector mode a factor divide (none when the factor is clamped) and three blends,
// quaternion mode three normalizations, each a square root and four divides
// reset clears the sequencer and config (key_count 1, track_kind 0); the key
// table has no reset and must be written before it is sampled
// the result sits on the ports for one cycle with done high; the receiver cannot
// stall it, and a new request may be taken in that same cycle
module keyframe_track_sampler (
    input  logic               clk,
    input  logic               rst_n,
    // request
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [5:0]         key_index,
    input  logic [31:0]        key_time,
    input  logic signed [31:0] comp_x,
    input  logic signed [31:0] comp_y,
    input  logic signed [31:0] comp_z,
    input  logic signed [31:0] comp_w,
    input  logic [31:0]        sample_time,
    // result
    output logic               done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic signed [31:0] out_w,
    output logic [1:0]         status,
    // config
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data
);

    // config registers; the user must write them only between requests, the block does not enforce it
    logic [6:0] key_count_reg;
    logic       track_kind_reg;

    kts_pkg::kts_cmd_t   cmd;
    kts_pkg::kts_flags_t flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg  <= 7'd1;
            track_kind_reg <= kts_pkg::KIND_VECTOR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kts_pkg::REG_KEY_COUNT:  key_count_reg  <= cfg_data;
                kts_pkg::REG_TRACK_KIND: track_kind_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer: key search, factor, blend, normalize and dot product steps
    kts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .opcode     (opcode),
        .key_count  (key_count_reg),
        .track_kind (track_kind_reg),
        .flags      (flags),
        .busy       (busy),
        .done       (done),
        .status     (status),
        .cmd        (cmd)
    );

    // key store, shared multiplier, divider and square root
    kts_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .track_kind  (track_kind_reg),
        .key_index   (key_index),
        .key_time    (key_time),
        .comp_x      (comp_x),
        .comp_y      (comp_y),
        .comp_z      (comp_z),
        .comp_w      (comp_w),
        .sample_time (sample_time),
        .flags       (flags),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .out_w       (out_w)
    );

endmodule

@@ test/keyframe_track_sampler_checker.sv @@
module keyframe_track_sampler_checker
    import kts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               opcode,
    input  logic [5:0]         key_index,
    input  logic [31:0]        key_time,
    input  logic signed [31:0] comp_x,
    input  logic signed [31:0] comp_y,
    input  logic signed [31:0] comp_z,
    input  logic signed [31:0] comp_w,
    input  logic [31:0]        sample_time,
    input  logic               done,
    input  logic signed [31:0] out_x,
    input  logic signed [31:0] out_y,
    input  logic signed [31:0] out_z,
    input  logic signed [31:0] out_w,
    input  logic [1:0]         status,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 checked
);

    typedef longint vec4_t [4];

    typedef struct {
        logic [31:0] c [4];
        logic [1:0]  st;
    } pose_t;

    logic [6:0]  count_reg;
    logic        kind_reg;
    logic [31:0] times [KEYS];
    vec4_t       values [KEYS];
    pose_t       poses_due [$];

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void unit4(input vec4_t v, output vec4_t o);
        longint unsigned s = 0;
        longint unsigned len, m, q;
        logic [64:0] acc;
        for (int k = 0; k < 4; k++) begin
            m = v[k] < 0 ? -v[k] : v[k];
            acc = {1'b0, s} + {1'b0, m * m};
            s = acc[64] ? '1 : acc[63:0];
        end
        len = int_sqrt(s);
        for (int k = 0; k < 4; k++) begin
            if (len == 0) o[k] = 0;
            else begin
                m = v[k] < 0 ? -v[k] : v[k];
                q = (m * 65536 + len / 2) / len;
                o[k] = v[k] < 0 ? -longint'(q) : longint'(q);
            end
        end
    endfunction

    // a*(1-f) + b*f, rounded half up in q16
    function automatic longint lerp1(longint a, longint b, longint f);
        longint q;
        q = a * (65536 - f) + b * f + 32768;
        if (q >= 0) return q >>> 16;
        return -((-q + 65535) >>> 16);
    endfunction

    function automatic pose_t sample_pose(logic [31:0] t);
        pose_t  p;
        int     n, seg;
        bit     hit;
        longint num, den, f;
        longint unsigned an, ad;
        vec4_t  r, qa, qb, mix;
        longint dot;
        n = count_reg == 0 ? 1 : (count_reg > KEYS ? KEYS : count_reg);
        p.st = ST_OK;
        seg = 0;
        hit = 0;
        if (n == 1) r = values[0];
        else begin
            for (int i = 0; i + 1 < n && !hit; i++)
                if (t < times[i+1]) begin
                    seg = i;
                    hit = 1;
                end
            if (!hit) p.st = ST_CLAMP;
            num = longint'({32'b0, t}) - longint'({32'b0, times[seg]});
            den = longint'({32'b0, times[seg+1]}) - longint'({32'b0, times[seg]});
            if (den == 0) begin
                p.st = ST_ZERO_SPAN;
                r = values[seg];
            end
            else begin
                an = num < 0 ? -num : num;
                ad = den < 0 ? -den : den;
                if (num != 0 && ((num < 0) != (den < 0))) begin
                    f = 0;
                    p.st = ST_CLAMP;
                end
                else if (an > ad) begin
                    f = 65536;
                    p.st = ST_CLAMP;
                end
                else f = longint'((an << 16) / ad);
                if (kind_reg == KIND_VECTOR) begin
                    for (int k = 0; k < 3; k++)
                        r[k] = lerp1(values[seg][k], values[seg+1][k], f);
                    r[3] = 0;
                end
                else begin
                    unit4(values[seg], qa);
                    unit4(values[seg+1], qb);
                    dot = 0;
                    for (int k = 0; k < 4; k++) dot += qa[k] * qb[k];
                    if (dot < 0) for (int k = 0; k < 4; k++) qb[k] = -qb[k];
                    for (int k = 0; k < 4; k++) mix[k] = lerp1(qa[k], qb[k], f);
                    unit4(mix, r);
                end
            end
        end
        if (kind_reg == KIND_VECTOR) r[3] = 0;
        for (int k = 0; k < 4; k++) p.c[k] = r[k][31:0];
        return p;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        pose_t got, want;
        bit    differ;
        if (!rst_n) begin
            count_reg  <= 1;
            kind_reg   <= KIND_VECTOR;
            fail_count <= 0;
            checked    <= 0;
            pending    <= 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == REG_KEY_COUNT) count_reg <= cfg_data;
                else kind_reg <= cfg_data[0];
            end
            if (start && !busy) begin
                if (opcode == OP_WRITE) begin
                    times[key_index]  = key_time;
                    values[key_index] = '{comp_x, comp_y, comp_z, comp_w};
                end
                else poses_due.insert(poses_due.size(), sample_pose(sample_time));
            end
            if (done) begin
                got.c = '{out_x, out_y, out_z, out_w};
                got.st = status;
                if (poses_due.size() == 0) begin
                    $display("%0t: unexpected result x=%h y=%h z=%h w=%h status=%0d",
                             $time, out_x, out_y, out_z, out_w, status);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = poses_due.pop_front();
                    checked <= checked + 1;
                    differ = got.st !== want.st;
                    for (int k = 0; k < 4; k++)
                        if (got.c[k] !== want.c[k]) differ = 1;
                    if (differ) begin
                        $display("%0t: expected x=%h y=%h z=%h w=%h status=%0d",
                                 $time, want.c[0], want.c[1], want.c[2], want.c[3], want.st);
                        $display("%0t: actual   x=%h y=%h z=%h w=%h status=%0d",
                                 $time, got.c[0], got.c[1], got.c[2], got.c[3], got.st);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= poses_due.size();
        end
    end

endmodule

@@ test/keyframe_track_sampler_tb.sv @@
module keyframe_track_sampler_tb;
    import kts_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic               opcode = OP_WRITE;
    logic [5:0]         key_index = 0;
    logic [31:0]        key_time = 0;
    logic signed [31:0] comp_x = 0, comp_y = 0, comp_z = 0, comp_w = 0;
    logic [31:0]        sample_time = 0;
    logic               done;
    logic signed [31:0] out_x, out_y, out_z, out_w;
    logic [1:0]         status;
    logic               cfg_we = 0;
    logic               cfg_index = REG_KEY_COUNT;
    logic [6:0]         cfg_data = 0;

    int fail_count, pending, checked;
    int requests_sent = 0;
    int idle_cycles = 0;
    bit no_gaps = 0;          // stretches where the sender never idles
    int live_keys = 1;        // effective key count after clamping
    logic [31:0] track_t [KEYS];

    localparam int WATCHDOG = 20000;

    always #1 clk = ~clk;

    keyframe_track_sampler dut (.*);

    keyframe_track_sampler_checker chk (.*);

    // watchdog: cycles with no request taken, no config write and no result seen
    always @(posedge clk) begin
        if ((start && !busy) || done || cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired at %0t", $time);
            $display("Mismatches found");
            $finish;
        end
    end

    // one request: random gap, then hold start until taken
    task automatic send_request(logic op, logic [5:0] idx, logic [31:0] kt,
                                logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic [31:0] w, logic [31:0] st);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1;
        opcode      <= op;
        key_index   <= idx;
        key_time    <= kt;
        comp_x      <= x;
        comp_y      <= y;
        comp_z      <= z;
        comp_w      <= w;
        sample_time <= st;
        do @(posedge clk); while (busy);
        requests_sent++;
    endtask

    // key writes carry a random sample_time too, so those bits toggle everywhere
    task automatic put_key(int idx, logic [31:0] kt, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [31:0] w);
        track_t[idx] = kt;
        send_request(OP_WRITE, 6'(idx), kt, x, y, z, w, $urandom);
    endtask

    task automatic sample_at(logic [31:0] t);
        send_request(OP_SAMPLE, 6'($urandom), $urandom, $urandom, $urandom,
                     $urandom, $urandom, t);
    endtask

    // register writes only once the block has drained
    task automatic write_reg(logic idx, logic [6:0] data);
        start <= 0;
        @(posedge clk);
        while (busy || pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == REG_KEY_COUNT)
            live_keys = data == 0 ? 1 : (data > KEYS ? KEYS : data);
    endtask

    // component values: mostly small q16 numbers, some extremes and raw noise
    function automatic logic [31:0] pick_comp();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 0;
            3, 4:    return $urandom;
            default: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
        endcase
    endfunction

    function automatic logic [31:0] pick_time();
        int i;
        logic [31:0] span;
        i = $urandom_range(0, live_keys - 1);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 32'hffff_ffff;
            2:       return track_t[i];
            3:       return $urandom;
            default: begin
                if (i + 1 < live_keys && track_t[i+1] > track_t[i])
                    span = track_t[i+1] - track_t[i];
                else
                    span = 32'h0002_0000;
                return track_t[i] + $urandom_range(0, span);
            end
        endcase
    endfunction

    // fresh table for slots 0..live_keys-1: sorted with random steps, or scrambled
    task automatic load_track(bit scrambled);
        logic [31:0] t;
        t = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4 * 65536);
        for (int i = 0; i < live_keys; i++) begin
            put_key(i, scrambled ? $urandom : t, pick_comp(), pick_comp(),
                    pick_comp(), pick_comp());
            // occasional repeated time gives a zero span
            if ($urandom_range(0, 7) != 0)
                t = t + $urandom_range(1, 6 * 65536);
        end
    endtask

    initial begin
        int phase_samples;
        int cnt;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: one key with extreme components, sampled at both time ends
        put_key(0, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 32'hffff_ffff);
        sample_at(0);
        sample_at(32'hffff_ffff);
        write_reg(REG_TRACK_KIND, 7'(KIND_QUAT));
        sample_at(32'h1234_5678);

        // four keys: a zero span between keys 1 and 2
        write_reg(REG_KEY_COUNT, 7'd4);
        put_key(1, 32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0001_0000);
        put_key(2, 32'h0001_0000, 0, 32'hffff_0000, 0, 32'hffff_0000);
        put_key(3, 32'h0003_0000, 0, 0, 32'h0002_0000, 0);
        for (int kd = 0; kd < 2; kd++) begin
            write_reg(REG_TRACK_KIND, 7'(kd == 0 ? KIND_VECTOR : KIND_QUAT));
            sample_at(32'h0000_8000);   // inside segment 0
            sample_at(32'h0001_0000);   // start of segment 2, factor zero
            sample_at(32'h0002_0000);   // middle of segment 2
            sample_at(32'h0003_0000);   // at the last key, clamped
        end
        // first span zero and sample past the end: zero span status
        put_key(1, 0, 32'h0000_1000, 32'h0000_2000, 32'h0000_3000, 32'h0000_4000);
        sample_at(32'hffff_ffff);
        // unsorted keys: factor above one gets clamped
        put_key(1, 32'h8000_0000, 32'h0001_0000, 0, 0, 0);
        put_key(0, 32'h9000_0000, 0, 0, 0, 32'h0001_0000);
        sample_at(32'h0000_0001);

        // random phases across key counts and both modes
        while (requests_sent < 1100) begin
            case ($urandom_range(0, 7))
                0:       cnt = 0;
                1:       cnt = $urandom_range(KEYS + 1, 127);
                2:       cnt = KEYS;
                3:       cnt = 1;
                default: cnt = $urandom_range(2, 8);
            endcase
            write_reg(REG_KEY_COUNT, 7'(cnt));
            write_reg(REG_TRACK_KIND, 7'($urandom_range(0, 1)));
            no_gaps = $urandom_range(0, 3) == 0;
            load_track($urandom_range(0, 5) == 0);
            phase_samples = $urandom_range(20, 60);
            for (int s = 0; s < phase_samples; s++) begin
                if ($urandom_range(0, 9) == 0)
                    put_key($urandom_range(0, live_keys - 1), pick_time(), pick_comp(),
                            pick_comp(), pick_comp(), pick_comp());
                sample_at(pick_time());
            end
        end

        start <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);

        $display("sent %0d requests (key writes and samples), checked %0d results",
                 requests_sent, checked);
        $display("covered key counts 0..127, vector and quaternion tracks, all statuses");
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ keyframe_track_sampler.f @@
hw/rtl/kts_pkg.sv
hw/rtl/kts_div.sv
hw/rtl/kts_sqrt.sv
hw/rtl/kts_datapath.sv
hw/rtl/kts_ctrl.sv
hw/rtl/keyframe_track_sampler.sv
test/keyframe_track_sampler_checker.sv
test/keyframe_track_sampler_tb.sv
